/* rtl/ppp_pkg.sv */
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types, register map, request codes and saturation helper for the
// particle pool.
// ----------------------------------------------------------------------------
package ppp_pkg;

  // request kinds carried in s_tuser
  localparam logic [1:0] REQ_SPAWN = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // register indexes (byte address 4*index)
  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_DRAG_H  = 2'd1;
  localparam logic [1:0] REG_DRAG_V  = 2'd2;

  localparam logic [23:0] GRAVITY_RESET = 24'd9830400;
  localparam logic [15:0] DRAG_H_RESET  = 16'd64225;
  localparam logic [15:0] DRAG_V_RESET  = 16'd64881;

  // one slot as it lies in the memory
  typedef struct packed {
    logic               live;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [15:0] life_left;
    logic        [15:0] life_start;
    logic        [31:0] tint;
    logic        [15:0] size;
  } slot_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ppp_ram.sv */
// ----------------------------------------------------------------------------
// ppp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ppp_integrate.sv */
// ----------------------------------------------------------------------------
// ppp_integrate
// Six-stage slot update pipeline: ageing and gravity, drag multiply, drag
// rounding, step multiply, step rounding, position add.
// ----------------------------------------------------------------------------
module ppp_integrate #(
  parameter int IW = 9
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [IW-1:0]   in_addr,
  input  ppp_pkg::slot_t  in_entry,
  input  logic [15:0]     dt,
  input  logic [26:0]     g,
  input  logic [15:0]     drag_h,
  input  logic [15:0]     drag_v,
  output logic            out_valid,
  output logic            out_freed,
  output logic [IW-1:0]   out_addr,
  output ppp_pkg::slot_t  out_entry,
  output logic            busy
);
  import ppp_pkg::*;

  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic s1_d, s2_d, s3_d, s4_d, s5_d, s6_d;
  logic [IW-1:0] s1_a, s2_a, s3_a, s4_a, s5_a, s6_a;
  slot_t s1_e, s2_e, s3_e, s4_e, s5_e, s6_e;
  slot_t s1_n, s3_n, s6_n;
  logic signed [48:0] p2_x, p2_y, p2_z;
  logic signed [48:0] p4_x, p4_y, p4_z;
  logic signed [31:0] d5_x, d5_y, d5_z;

  logic signed [47:0] vy_wide;
  logic signed [48:0] r3_x, r3_y, r3_z;
  logic signed [48:0] r5_x, r5_y, r5_z;
  logic               dead;

  assign dead    = in_entry.life_left <= dt;
  assign vy_wide = 48'(in_entry.vel_y) - $signed({21'd0, g});

  // truncation toward zero: bias negative values before the arithmetic shift
  assign r3_x = p2_x + (p2_x[48] ? 49'sd65535 : 49'sd0);
  assign r3_y = p2_y + (p2_y[48] ? 49'sd65535 : 49'sd0);
  assign r3_z = p2_z + (p2_z[48] ? 49'sd65535 : 49'sd0);
  assign r5_x = p4_x + (p4_x[48] ? 49'sd8191 : 49'sd0);
  assign r5_y = p4_y + (p4_y[48] ? 49'sd8191 : 49'sd0);
  assign r5_z = p4_z + (p4_z[48] ? 49'sd8191 : 49'sd0);

  always_comb begin
    s1_n           = in_entry;
    s1_n.life_left = in_entry.life_left - dt;
    s1_n.vel_y     = sat32(vy_wide);
    s3_n           = s2_e;
    s3_n.vel_x     = r3_x[47:16];
    s3_n.vel_y     = r3_y[47:16];
    s3_n.vel_z     = r3_z[47:16];
    s6_n           = s5_e;
    s6_n.live      = !s5_d;
    s6_n.pos_x     = sat32(48'(s5_e.pos_x) + 48'(d5_x));
    s6_n.pos_y     = sat32(48'(s5_e.pos_y) + 48'(d5_y));
    s6_n.pos_z     = sat32(48'(s5_e.pos_z) + 48'(d5_z));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      s1_v <= in_valid && in_entry.live;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: ageing and gravity
    s1_a <= in_addr;
    s1_d <= dead;
    s1_e <= s1_n;
    // stage 2: drag products
    s2_a <= s1_a;
    s2_d <= s1_d;
    s2_e <= s1_e;
    p2_x <= s1_e.vel_x * $signed({1'b0, drag_h});
    p2_y <= s1_e.vel_y * $signed({1'b0, drag_v});
    p2_z <= s1_e.vel_z * $signed({1'b0, drag_h});
    // stage 3: new velocity
    s3_a <= s2_a;
    s3_d <= s2_d;
    s3_e <= s3_n;
    // stage 4: velocity times dt
    s4_a <= s3_a;
    s4_d <= s3_d;
    s4_e <= s3_e;
    p4_x <= s3_e.vel_x * $signed({1'b0, dt});
    p4_y <= s3_e.vel_y * $signed({1'b0, dt});
    p4_z <= s3_e.vel_z * $signed({1'b0, dt});
    // stage 5: position step
    s5_a <= s4_a;
    s5_d <= s4_d;
    s5_e <= s4_e;
    d5_x <= sat32(48'($signed(r5_x[48:13])));
    d5_y <= sat32(48'($signed(r5_y[48:13])));
    d5_z <= sat32(48'($signed(r5_z[48:13])));
    // stage 6: position update
    s6_a <= s5_a;
    s6_d <= s5_d;
    s6_e <= s6_n;
  end

  assign out_valid = s6_v;
  assign out_freed = s6_d;
  assign out_addr  = s6_a;
  assign out_entry = s6_e;
  assign busy      = s1_v | s2_v | s3_v | s4_v | s5_v | s6_v;

endmodule

/* rtl/particle_pool_physics.sv */
// ----------------------------------------------------------------------------
// particle_pool_physics
// Pool of particle slots with spawn, tick, clear and read requests.
//
// Requests enter on s_tvalid/s_tready; s_tuser holds the request kind and
// s_tdata the spawn fields, tick dt and read index. Every request gives one
// response on m_tvalid/m_tready. Registers (gravity, drag) sit on the APB
// port; the user must write them only while the pool is idle, the block itself does not enforce it.
// All slot state lives in one memory of SLOT_COUNT entries with a registered
// read; a request is handled alone, and the next is accepted once its
// response is staged in the output register, even while the receiver stalls.
// Work per request, set by one memory access per slot:
//   spawn  : scan in index order up to the first free slot (every slot when the pool is full)
//   tick   : every slot, one slot per cycle through a 6-stage pipeline
//   clear  : write sweep over every slot
//   read   : a single slot read
// After reset a sweep over all SLOT_COUNT slots marks every slot free; no request
// is taken during it. A stalled receiver holds the response in m_tdata and
// the pool waits with the next result until it is taken.
// ----------------------------------------------------------------------------
module particle_pool_physics #(
  parameter int SLOT_COUNT = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, tint, size, life, tick_dt,
  // read_slot, 7 bits zero
  input  logic [287:0] s_tdata,
  // req_type
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // slot_index, pos_x, pos_y, pos_z, life, start_life, tint, size,
  // live_count, 5 bits zero
  output logic [199:0] m_tdata,
  // accepted, slot_active
  output logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ppp_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = IW + 1;
  localparam int LW = $clog2(SLOT_COUNT + 1);
  localparam int AW = (IW > 9) ? IW : 9;
  localparam logic [CW-1:0] LAST = CW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] ENDC = CW'(SLOT_COUNT);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CLEAR = 4'd2;
  localparam logic [3:0] ST_SPAWN = 4'd3;
  localparam logic [3:0] ST_GRAV  = 4'd4;
  localparam logic [3:0] ST_TICK  = 4'd5;
  localparam logic [3:0] ST_READ  = 4'd6;
  localparam logic [3:0] ST_RDATA = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]    state;
  logic [CW-1:0] icnt;
  logic [LW-1:0] live_total;
  logic [23:0]   gravity;
  logic [15:0]   drag_h;
  logic [15:0]   drag_v;

  slot_t         spawn_e;
  logic [15:0]   dt_q;
  logic [8:0]    rd_q;
  logic [26:0]   g_q;
  logic          pend;
  logic [IW-1:0] pend_addr;
  logic          rvalid;
  logic [IW-1:0] raddr_q;

  logic          res_acc;
  logic          res_active;
  logic [8:0]    res_idx;
  slot_t         res_e;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata;
  logic [IW-1:0] ram_raddr;
  slot_t         ram_rdata;

  logic          wb_valid;
  logic          wb_freed;
  logic [IW-1:0] wb_addr;
  slot_t         wb_entry;
  logic          pipe_busy;

  logic [AW-1:0] rd_ext;
  logic [IW-1:0] rd_addr;
  logic          rd_in_range;
  logic          found;
  logic          issue;
  logic          cfg_wr;
  logic          out_load;
  logic [39:0]   g_prod;
  slot_t         in_e;

  assign rd_ext      = AW'(rd_q);
  assign rd_addr     = rd_ext[IW-1:0];
  assign rd_in_range = 32'(rd_q) < SLOT_COUNT;
  assign found       = (state == ST_SPAWN) && pend && !ram_rdata.live;
  assign issue       = (state == ST_TICK) && (icnt < ENDC);
  assign cfg_wr      = psel && penable && pwrite;
  assign out_load    = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign g_prod      = 40'(gravity) * 40'(dt_q);
  assign s_tready    = (state == ST_IDLE);
  assign pready      = 1'b1;

  always_comb begin
    in_e            = '0;
    in_e.live       = 1'b1;
    in_e.pos_x      = s_tdata[31:0];
    in_e.pos_y      = s_tdata[63:32];
    in_e.pos_z      = s_tdata[95:64];
    in_e.vel_x      = s_tdata[127:96];
    in_e.vel_y      = s_tdata[159:128];
    in_e.vel_z      = s_tdata[191:160];
    in_e.tint       = s_tdata[223:192];
    in_e.size       = s_tdata[239:224];
    in_e.life_left  = s_tdata[255:240];
    in_e.life_start = s_tdata[255:240];
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GRAVITY: prdata = 32'(gravity);
      REG_DRAG_H:  prdata = 32'(drag_h);
      REG_DRAG_V:  prdata = 32'(drag_v);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    ram_raddr = ((state == ST_SPAWN) || (state == ST_TICK)) ? icnt[IW-1:0] : rd_addr;
    ram_we    = 1'b0;
    ram_waddr = icnt[IW-1:0];
    ram_wdata = '0;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_SPAWN: begin
        ram_we    = found;
        ram_waddr = pend_addr;
        ram_wdata = spawn_e;
      end
      ST_TICK: begin
        ram_we    = wb_valid;
        ram_waddr = wb_addr;
        ram_wdata = wb_entry;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ppp_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // reads run ahead of write-back in address order, so a slot is never
  // read while its own update is still in flight
  ppp_integrate #(
    .IW (IW)
  ) u_integrate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rvalid),
    .in_addr   (raddr_q),
    .in_entry  (ram_rdata),
    .dt        (dt_q),
    .g         (g_q),
    .drag_h    (drag_h),
    .drag_v    (drag_v),
    .out_valid (wb_valid),
    .out_freed (wb_freed),
    .out_addr  (wb_addr),
    .out_entry (wb_entry),
    .busy      (pipe_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= GRAVITY_RESET;
      drag_h  <= DRAG_H_RESET;
      drag_v  <= DRAG_V_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_GRAVITY: gravity <= pwdata[23:0];
        REG_DRAG_H:  drag_h  <= pwdata[15:0];
        REG_DRAG_V:  drag_v  <= pwdata[15:0];
        default:     gravity <= gravity;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      icnt       <= '0;
      live_total <= '0;
      m_tvalid   <= 1'b0;
      pend       <= 1'b0;
      rvalid     <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          icnt <= icnt + 1'b1;
          if (icnt == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          icnt   <= '0;
          pend   <= 1'b0;
          rvalid <= 1'b0;
          if (s_tvalid) begin
            spawn_e    <= in_e;
            dt_q       <= s_tdata[271:256];
            rd_q       <= s_tdata[280:272];
            res_acc    <= 1'b0;
            res_active <= 1'b0;
            res_idx    <= '0;
            res_e      <= '0;
            unique case (s_tuser)
              REQ_SPAWN: state <= ST_SPAWN;
              REQ_TICK:  state <= ST_GRAV;
              REQ_CLEAR: state <= ST_CLEAR;
              REQ_READ:  state <= ST_READ;
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_CLEAR: begin
          icnt <= icnt + 1'b1;
          if (icnt == LAST) begin
            live_total <= '0;
            state      <= ST_OUT;
          end
        end
        ST_SPAWN: begin
          pend      <= 1'b1;
          pend_addr <= icnt[IW-1:0];
          icnt      <= icnt + 1'b1;
          if (found) begin
            res_acc    <= 1'b1;
            res_idx    <= 9'(pend_addr);
            live_total <= live_total + 1'b1;
            state      <= ST_OUT;
          end else if (pend && (CW'(pend_addr) == LAST)) begin
            // pool full: refuse
            state <= ST_OUT;
          end
        end
        ST_GRAV: begin
          g_q   <= g_prod[39:13];
          state <= ST_TICK;
        end
        ST_TICK: begin
          rvalid  <= issue;
          raddr_q <= icnt[IW-1:0];
          if (issue) begin
            icnt <= icnt + 1'b1;
          end
          if (wb_valid && wb_freed) begin
            live_total <= live_total - 1'b1;
          end
          if (!issue && !rvalid && !pipe_busy) begin
            state <= ST_OUT;
          end
        end
        ST_READ: begin
          state <= ST_RDATA;
        end
        ST_RDATA: begin
          res_idx <= rd_q;
          if (rd_in_range && ram_rdata.live) begin
            res_active <= 1'b1;
            res_e      <= ram_rdata;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= {res_active, res_acc};
      m_tdata <= {5'd0, 10'(live_total), res_e.size, res_e.tint, res_e.life_start,
                  res_e.life_left, res_e.pos_z, res_e.pos_y, res_e.pos_x, res_idx};
    end
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    32'(live_total) <= SLOT_COUNT)
    else $error("live count above pool size");

  a_tick_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (issue && ram_we) |-> (ram_waddr != ram_raddr))
    else $error("tick reads a slot that is being written back");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in work");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("spawn accept and read active in one response");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle pool testbench
// Sends spawn, tick, clear and read requests to the particle pool under
// several drag and gravity settings and varied idling on both sides. A
// scoreboard computes every response from its own copy of the pool and
// compares each response field by field, oldest first.
// ----------------------------------------------------------------------------
module testbench;
  import ppp_pkg::*;

  localparam int SLOTS = 512;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic [31:0]        tint;
    logic [15:0]        size, life, dt;
    logic [8:0]         rslot;
  } pool_req_t;

  typedef struct packed {
    logic        acc;
    logic [8:0]  idx;
    logic        act;
    logic [31:0] px, py, pz;
    logic [15:0] life, start;
    logic [31:0] tint;
    logic [15:0] size;
    logic [9:0]  cnt;
  } pool_resp_t;

  class pool_scoreboard;
    bit                 live[SLOTS];
    bit signed [31:0]   px[SLOTS], py[SLOTS], pz[SLOTS];
    bit signed [31:0]   vx[SLOTS], vy[SLOTS], vz[SLOTS];
    bit [15:0]          left[SLOTS], start[SLOTS], size[SLOTS];
    bit [31:0]          tint[SLOTS];
    int                 total = 0;
    bit [23:0]          grav = GRAVITY_RESET;
    bit [15:0]          drag_h = DRAG_H_RESET;
    bit [15:0]          drag_v = DRAG_V_RESET;
    pool_resp_t         waiting[$];
    int                 errors = 0;
    int                 refused = 0;
    int                 checked = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_GRAVITY: grav = v[23:0];
        REG_DRAG_H:  drag_h = v[15:0];
        REG_DRAG_V:  drag_v = v[15:0];
        default: ;
      endcase
    endfunction

    function bit signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function bit signed [31:0] slow(bit signed [31:0] v, bit [15:0] f);
      longint p;
      p = (longint'(v) * longint'({16'd0, f})) / 65536;
      return p[31:0];
    endfunction

    function bit signed [31:0] move(bit signed [31:0] p, bit signed [31:0] v,
                                     bit [15:0] dt);
      bit signed [31:0] d;
      d = clamp32((longint'(v) * longint'({16'd0, dt})) / 8192);
      return clamp32(longint'(p) + longint'(d));
    endfunction

    function void age_all(bit [15:0] dt);
      longint g;
      g = (longint'({8'd0, grav}) * longint'({16'd0, dt})) >>> 13;
      for (int i = 0; i < SLOTS; i++) begin
        if (!live[i]) continue;
        if (left[i] <= dt) begin
          live[i] = 0;
          total--;
          continue;
        end
        left[i] = left[i] - dt;
        vy[i] = clamp32(longint'(vy[i]) - g);
        vx[i] = slow(vx[i], drag_h);
        vy[i] = slow(vy[i], drag_v);
        vz[i] = slow(vz[i], drag_h);
        px[i] = move(px[i], vx[i], dt);
        py[i] = move(py[i], vy[i], dt);
        pz[i] = move(pz[i], vz[i], dt);
      end
    endfunction

    function void note_request(pool_req_t r);
      pool_resp_t e;
      bit found;
      e = '0;
      found = 0;
      case (r.kind)
        REQ_SPAWN: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (live[i]) continue;
            px[i] = r.px; py[i] = r.py; pz[i] = r.pz;
            vx[i] = r.vx; vy[i] = r.vy; vz[i] = r.vz;
            tint[i] = r.tint; size[i] = r.size;
            left[i] = r.life; start[i] = r.life;
            live[i] = 1;
            total++;
            e.acc = 1;
            e.idx = 9'(i);
            found = 1;
            break;
          end
          if (!found) refused++;
        end
        REQ_TICK: age_all(r.dt);
        REQ_CLEAR: begin
          foreach (live[i]) live[i] = 0;
          total = 0;
        end
        default: begin
          e.idx = r.rslot;
          if (live[r.rslot]) begin
            e.act = 1;
            e.px = px[r.rslot]; e.py = py[r.rslot]; e.pz = pz[r.rslot];
            e.life = left[r.rslot]; e.start = start[r.rslot];
            e.tint = tint[r.rslot]; e.size = size[r.rslot];
          end
        end
      endcase
      e.cnt = 10'(total);
      waiting.push_back(e);
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_response(logic [199:0] d, logic [1:0] u);
      pool_resp_t e;
      if (waiting.size() == 0) begin
        errors++;
        $display("%0t: response with nothing expected, actual %h %h", $time, u, d);
        return;
      end
      e = waiting.pop_front();
      checked++;
      compare("accepted", e.acc, u[0]);
      compare("slot_active", e.act, u[1]);
      compare("slot_index", e.idx, d[8:0]);
      compare("pos_x", e.px, d[40:9]);
      compare("pos_y", e.py, d[72:41]);
      compare("pos_z", e.pz, d[104:73]);
      compare("life", e.life, d[120:105]);
      compare("start_life", e.start, d[136:121]);
      compare("tint", e.tint, d[168:137]);
      compare("size", e.size, d[184:169]);
      compare("live_count", e.cnt, d[194:185]);
    endfunction

    function int pick_live();
      int s;
      s = $urandom_range(SLOTS - 1);
      for (int k = 0; k < SLOTS; k++)
        if (live[(s + k) % SLOTS]) return (s + k) % SLOTS;
      return -1;
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [199:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  pool_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold = 0;
  int kind_count[4] = '{0, 0, 0, 0};

  particle_pool_physics uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver side
  always @(posedge clk) begin
    m_tready <= !hold && ($urandom_range(99) >= stall_pct);
    if (m_tvalid && m_tready) sb.check_response(m_tdata, m_tuser);
  end

  initial begin
    #8ms;
    $display("Verification failed");
    $finish;
  end

  task automatic send_request(pool_req_t r);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.kind;
    s_tdata <= {7'd0, r.rslot, r.dt, r.life, r.size, r.tint,
                r.vz, r.vy, r.vx, r.pz, r.py, r.px};
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
    kind_count[r.kind]++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.waiting.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_physics(logic [31:0] g, logic [31:0] h, logic [31:0] v);
    write_reg(REG_GRAVITY, g);
    write_reg(REG_DRAG_H, h);
    write_reg(REG_DRAG_V, v);
  endtask

  function automatic logic [31:0] wide_value();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return $urandom();
      default: return $signed($urandom_range(2097151)) - 32'sd1048576;
    endcase
  endfunction

  function automatic pool_req_t random_fill();
    pool_req_t r;
    r.kind = REQ_SPAWN;
    r.px = wide_value(); r.py = wide_value(); r.pz = wide_value();
    r.vx = wide_value(); r.vy = wide_value(); r.vz = wide_value();
    r.tint = $urandom();
    r.size = 16'($urandom());
    case ($urandom_range(19))
      0: r.life = 16'd0;
      1: r.life = 16'hffff;
      default: r.life = 16'($urandom_range(40000, 1));
    endcase
    case ($urandom_range(19))
      0: r.dt = 16'd0;
      1: r.dt = 16'hffff;
      2, 3: r.dt = 16'($urandom());
      default: r.dt = 16'($urandom_range(4000));
    endcase
    r.rslot = 9'($urandom());
    return r;
  endfunction

  function automatic pool_req_t random_request();
    pool_req_t r;
    int pick;
    int s;
    r = random_fill();
    pick = $urandom_range(99);
    if (sb.total > 48) pick = (pick < 60) ? 95 : pick;
    if (pick < 40) r.kind = REQ_SPAWN;
    else if (pick < 70) begin
      r.kind = REQ_READ;
      s = sb.pick_live();
      if (s >= 0 && $urandom_range(9) < 8) r.rslot = 9'(s);
    end else if (pick < 94) r.kind = REQ_TICK;
    else r.kind = ($urandom_range(2) == 0) ? REQ_CLEAR : REQ_TICK;
    return r;
  endfunction

  task automatic run_phase(int idle, int stall, int count);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_request(random_request());
    drain();
  endtask

  initial begin
    pool_req_t r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // wait for the free sweep after reset
    do @(posedge clk); while (!s_tready);
    repeat (4) @(posedge clk);
    set_physics(GRAVITY_RESET, DRAG_H_RESET, DRAG_V_RESET);

    // directed part
    r = random_fill();
    r.px = 32'h7fffffff; r.py = 32'h80000000; r.pz = 32'h7fffffff;
    r.vx = 32'h7fffffff; r.vy = 32'h80000000; r.vz = 32'h80000000;
    r.tint = 32'hffffffff; r.size = 16'hffff; r.life = 16'hffff;
    send_request(r);
    r.px = 32'h80000000; r.py = 32'h7fffffff; r.pz = 32'h0;
    r.vx = 32'h80000000; r.vy = 32'h7fffffff; r.vz = 32'h0;
    r.tint = 32'h0; r.size = 16'h0; r.life = 16'h0;
    send_request(r);
    r = random_fill(); r.life = 16'd20000; send_request(r);
    r.kind = REQ_READ;
    for (int i = 0; i < 4; i++) begin
      r.rslot = 9'(i);
      send_request(r);
    end
    r.rslot = 9'd511; send_request(r);
    r.kind = REQ_TICK; r.dt = 16'd0; send_request(r);
    r.kind = REQ_READ; r.rslot = 0; send_request(r);
    r.rslot = 1; send_request(r);
    r.kind = REQ_TICK; r.dt = 16'd8192; send_request(r);
    r.kind = REQ_READ;
    for (int i = 0; i < 3; i++) begin
      r.rslot = 9'(i);
      send_request(r);
    end
    r.kind = REQ_TICK; r.dt = 16'hffff; send_request(r);
    r.kind = REQ_READ; r.rslot = 0; send_request(r);
    r = random_fill(); send_request(r);
    r.kind = REQ_CLEAR; send_request(r);
    r.kind = REQ_READ; r.rslot = 0; send_request(r);
    r.kind = REQ_TICK; r.dt = 16'd100; send_request(r);
    drain();

    run_phase(0, 0, 100);
    set_physics(32'h0, 32'h0, 32'h0);
    run_phase(73, 0, 100);
    set_physics(32'hffffff, 32'hffff, 32'hffff);
    run_phase(0, 73, 100);
    set_physics($urandom(), $urandom(), $urandom());
    run_phase(15, 15, 100);

    // long receiver hold-off while requests keep coming
    set_physics(GRAVITY_RESET, DRAG_H_RESET, DRAG_V_RESET);
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold = 1;
        repeat (3000) @(posedge clk);
        hold = 0;
      end
    join_none
    repeat (12) send_request(random_request());
    drain();

    // short closing sequence
    r = random_fill();
    r.kind = REQ_TICK; r.dt = 16'd50; send_request(r);
    r.kind = REQ_READ; r.rslot = 9'd511; send_request(r);
    r.kind = REQ_SPAWN; send_request(r);
    r.kind = REQ_CLEAR; send_request(r);
    drain();

    $display("covered %0d spawns (%0d refused), %0d ticks, %0d clears, %0d reads",
             kind_count[REQ_SPAWN], sb.refused, kind_count[REQ_TICK],
             kind_count[REQ_CLEAR], kind_count[REQ_READ]);
    $display("%0d responses checked across five register settings", sb.checked);
    if (sb.errors == 0 && sb.waiting.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
